/* rtl/core/box_measurement_merge_table_assert.svh */
// Assertion helpers for the box merge table.
`ifndef BOX_MEASUREMENT_MERGE_TABLE_ASSERT_SVH
`define BOX_MEASUREMENT_MERGE_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BMMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmmt assertion failed");

// Next-cycle implication, checked out of reset.
`define BMMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmmt assertion failed");

`endif

/* rtl/core/bmmt_pkg.sv */
package bmmt_pkg;

    localparam int COORD_W = 16;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [2:0] t_vec3;

    // Request into the running-mean unit
    typedef struct packed {
        logic   start;
        t_coord old_v;
        t_coord new_v;
    } t_mean_req;

    // Request functions
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_EMIT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_MERGED  = 3'd0;
    localparam logic [2:0] STAT_ADDED   = 3'd1;
    localparam logic [2:0] STAT_DROPPED = 3'd2;
    localparam logic [2:0] STAT_EMITTED = 3'd3;
    localparam logic [2:0] STAT_END     = 3'd4;

    // Register index (address bit 2)
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_MINCAP = 1'b1;

endpackage

/* rtl/core/bmmt_dist.sv */
module bmmt_dist (
    input  logic           i_clk,
    input  logic           i_load,
    input  bmmt_pkg::t_vec3 i_a_size,
    input  bmmt_pkg::t_vec3 i_a_cen,
    input  bmmt_pkg::t_vec3 i_b_size,
    input  bmmt_pkg::t_vec3 i_b_cen,
    input  logic [19:0]    i_r2,
    output logic           o_match
);
    import bmmt_pkg::*;

    logic [31:0] r_sq_s [3];
    logic [31:0] r_sq_c [3];
    logic [31:0] n_sq_s [3];
    logic [31:0] n_sq_c [3];
    logic [33:0] sum_s;
    logic [33:0] sum_c;

    function automatic logic [31:0] sq_diff(input t_coord a, input t_coord b);
        logic signed [16:0] d;
        logic [16:0] m;
        d = 17'(a) - 17'(b);
        m = d[16] ? 17'(-d) : 17'(d);
        return m[15:0] * m[15:0];
    endfunction

    // Square each axis difference
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sq_s[k] = sq_diff(i_a_size[k], i_b_size[k]);
            n_sq_c[k] = sq_diff(i_a_cen[k], i_b_cen[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq_s <= n_sq_s;
            r_sq_c <= n_sq_c;
        end
    end

    // Sum and gate against radius squared
    assign sum_s = 34'(r_sq_s[0]) + 34'(r_sq_s[1]) + 34'(r_sq_s[2]);
    assign sum_c = 34'(r_sq_c[0]) + 34'(r_sq_c[1]) + 34'(r_sq_c[2]);
    assign o_match = (sum_s < 34'(i_r2)) && (sum_c < 34'(i_r2));

endmodule

/* rtl/core/bmmt_mean.sv */
module bmmt_mean #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bmmt_pkg::t_mean_req   i_req,
    input  logic [COUNT_BITS-1:0] i_w,
    output logic                  o_done,
    output bmmt_pkg::t_coord      o_q
);
    import bmmt_pkg::*;

    localparam int PW = COUNT_BITS + 17;
    localparam int NW = COUNT_BITS + 18;
    localparam int RW = COUNT_BITS + 17;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_ABS  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    logic [1:0]             r_st;
    logic [4:0]             r_cnt;
    logic                   r_done;
    logic signed [PW-1:0]   r_prod;
    t_coord                 r_new;
    logic [COUNT_BITS:0]    r_div;
    logic                   r_neg;
    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          r_sh;
    logic [16:0]            r_q;
    logic signed [PW-1:0]   prod;
    logic signed [NW-1:0]   num;
    logic [NW-1:0]          mag;

    assign prod = $signed({1'b0, i_w}) * i_req.old_v;
    assign num  = r_prod + r_new;
    assign mag  = num[NW-1] ? NW'(-num) : NW'(num);

    // Control: multiply, take magnitude, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= M_IDLE;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                M_IDLE: if (i_req.start) r_st <= M_ABS;
                M_ABS: begin
                    r_cnt <= 5'd16;
                    r_st  <= M_DIV;
                end
                M_DIV: begin
                    if (r_cnt == 5'd0) begin
                        r_done <= 1'b1;
                        r_st   <= M_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: r_st <= M_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_st == M_IDLE && i_req.start) begin
            r_prod <= prod;
            r_new  <= i_req.new_v;
            r_div  <= (COUNT_BITS+1)'({1'b0, i_w}) + (COUNT_BITS+1)'(1);
        end
        if (r_st == M_ABS) begin
            r_neg <= num[NW-1];
            r_rem <= mag[RW-1:0];
            r_sh  <= RW'(r_div) << 16;
            r_q   <= '0;
        end
        if (r_st == M_DIV) begin
            if (r_rem >= r_sh) begin
                r_rem <= r_rem - r_sh;
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_q   <= {r_q[15:0], 1'b0};
            end
            r_sh <= r_sh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? 16'(-r_q) : 16'(r_q);

endmodule

/* rtl/core/box_measurement_merge_table.sv */
// Box measurement merge table. Requests carry a function (add, emit then clear, clear) and a
// box size and centre in signed millimetres; entries live in one synchronous memory and are
// handled one request at a time. An add scans the filled entries in order, each through a
// memory read, squared distances and a compare; a matching entry is then updated by six
// running means from a shared bit-serial divider, one after another, and is then written
// back. An emit steps through the filled entries and then gives the end marker; a clear
// gives the end marker only. Results pass through an output register, so a new request is
// taken while the last result waits. Registers: match_radius at byte address 0 (reset 50),
// min_captures at address 4 (reset 1). No clearing pass is needed.
`include "box_measurement_merge_table_assert.svh"

module box_measurement_merge_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  bmmt_pkg::t_coord   i_size_x,
    input  bmmt_pkg::t_coord   i_size_y,
    input  bmmt_pkg::t_coord   i_size_z,
    input  bmmt_pkg::t_coord   i_centre_x,
    input  bmmt_pkg::t_coord   i_centre_y,
    input  bmmt_pkg::t_coord   i_centre_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [4:0]         o_entry_index,
    output bmmt_pkg::t_coord   o_out_size_x,
    output bmmt_pkg::t_coord   o_out_size_y,
    output bmmt_pkg::t_coord   o_out_size_z,
    output bmmt_pkg::t_coord   o_out_centre_x,
    output bmmt_pkg::t_coord   o_out_centre_y,
    output bmmt_pkg::t_coord   o_out_centre_z,
    output logic [15:0]        o_capture_count,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bmmt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = COUNT_BITS + 96;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_MEAN  = 4'd4;
    localparam logic [3:0] S_MWAIT = 4'd5;
    localparam logic [3:0] S_MWR   = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;
    localparam logic [3:0] S_ERD   = 4'd8;
    localparam logic [3:0] S_ECHK  = 4'd9;
    localparam logic [3:0] S_END   = 4'd10;

    logic [3:0]            r_state, n_state;
    logic [FW-1:0]         r_idx, n_idx;
    logic [FW-1:0]         r_fill, n_fill;
    logic [2:0]            r_k, n_k;
    t_vec3                 r_size, r_cen;
    t_vec3                 r_msize, r_mcen;
    logic [9:0]            r_radius;
    logic [15:0]           r_mincap;
    logic [19:0]           r_r2;
    logic [EW-1:0]         mem [TABLE_DEPTH];
    logic [EW-1:0]         r_rdata;

    logic                  r_ov, n_ov;
    logic [2:0]            r_ostat, n_ostat;
    logic [4:0]            r_oidx, n_oidx;
    t_vec3                 r_osize, n_osize;
    t_vec3                 r_ocen, n_ocen;
    logic [15:0]           r_ocnt, n_ocnt;
    logic                  r_olast, n_olast;

    logic                  out_free;
    logic                  accept;
    logic                  mem_re, mem_we;
    logic [EW-1:0]         mem_wdata;
    t_vec3                 e_size, e_cen;
    logic [COUNT_BITS-1:0] e_cnt, cnt_inc;
    logic                  dist_load, dist_match;
    t_mean_req             mean_req;
    logic                  mean_done;
    t_coord                mean_q;

    assign e_size  = r_rdata[47:0];
    assign e_cen   = r_rdata[95:48];
    assign e_cnt   = r_rdata[EW-1:96];
    assign cnt_inc = (e_cnt == CMAX) ? e_cnt : e_cnt + COUNT_BITS'(1);

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    // Configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 10'd50;
            r_mincap <= 16'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_RADIUS: r_radius <= pwdata[9:0];
                REG_MINCAP: r_mincap <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RADIUS: prdata = 32'(r_radius);
            REG_MINCAP: prdata = 32'(r_mincap);
            default:    prdata = '0;
        endcase
    end

    // Radius squared, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_idx[IW-1:0]] <= mem_wdata;
        if (mem_re) r_rdata <= mem[r_idx[IW-1:0]];
    end

    bmmt_dist u_dist (
        .i_clk    (i_clk),
        .i_load   (dist_load),
        .i_a_size (r_size),
        .i_a_cen  (r_cen),
        .i_b_size (e_size),
        .i_b_cen  (e_cen),
        .i_r2     (r_r2),
        .o_match  (dist_match)
    );

    // Select the component for the mean unit
    always_comb begin
        mean_req.start = (r_state == S_MEAN);
        case (r_k)
            3'd0:    begin mean_req.old_v = e_size[0]; mean_req.new_v = r_size[0]; end
            3'd1:    begin mean_req.old_v = e_size[1]; mean_req.new_v = r_size[1]; end
            3'd2:    begin mean_req.old_v = e_size[2]; mean_req.new_v = r_size[2]; end
            3'd3:    begin mean_req.old_v = e_cen[0];  mean_req.new_v = r_cen[0];  end
            3'd4:    begin mean_req.old_v = e_cen[1];  mean_req.new_v = r_cen[1];  end
            default: begin mean_req.old_v = e_cen[2];  mean_req.new_v = r_cen[2];  end
        endcase
    end

    bmmt_mean #(.COUNT_BITS(COUNT_BITS)) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mean_req),
        .i_w     (e_cnt),
        .o_done  (mean_done),
        .o_q     (mean_q)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_k       = r_k;
        n_ov      = r_ov && !i_ready;
        n_ostat   = r_ostat;
        n_oidx    = r_oidx;
        n_osize   = r_osize;
        n_ocen    = r_ocen;
        n_ocnt    = r_ocnt;
        n_olast   = r_olast;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = {cnt_inc, r_mcen, r_msize};
        dist_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    case (i_func)
                        FUNC_ADD:   n_state = S_RD;
                        FUNC_EMIT:  n_state = S_ERD;
                        FUNC_CLEAR: n_state = S_END;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                if (r_idx == r_fill) begin
                    n_state = S_ADD;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                dist_load = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (dist_match) begin
                    n_k     = '0;
                    n_state = S_MEAN;
                end else begin
                    n_idx   = r_idx + FW'(1);
                    n_state = S_RD;
                end
            end
            S_MEAN: n_state = S_MWAIT;
            S_MWAIT: begin
                if (mean_done) begin
                    if (r_k == 3'd5) begin
                        n_state = S_MWR;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_MEAN;
                    end
                end
            end
            S_MWR: begin
                if (out_free) begin
                    mem_we  = 1'b1;
                    n_ov    = 1'b1;
                    n_ostat = STAT_MERGED;
                    n_oidx  = 5'(r_idx);
                    n_osize = r_msize;
                    n_ocen  = r_mcen;
                    n_ocnt  = 16'(cnt_inc);
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                    if (r_fill == FW'(TABLE_DEPTH)) begin
                        n_ostat = STAT_DROPPED;
                        n_oidx  = '0;
                        n_osize = '0;
                        n_ocen  = '0;
                        n_ocnt  = '0;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {COUNT_BITS'(1), r_cen, r_size};
                        n_ostat   = STAT_ADDED;
                        n_oidx    = 5'(r_idx);
                        n_osize   = r_size;
                        n_ocen    = r_cen;
                        n_ocnt    = 16'd1;
                        n_fill    = r_fill + FW'(1);
                    end
                end
            end
            S_ERD: begin
                if (r_idx == r_fill) begin
                    n_state = S_END;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (CW'(e_cnt) >= CW'(r_mincap)) begin
                    if (out_free) begin
                        n_ov    = 1'b1;
                        n_ostat = STAT_EMITTED;
                        n_oidx  = 5'(r_idx);
                        n_osize = e_size;
                        n_ocen  = e_cen;
                        n_ocnt  = 16'(e_cnt);
                        n_olast = 1'b0;
                        n_idx   = r_idx + FW'(1);
                        n_state = S_ERD;
                    end
                end else begin
                    n_idx   = r_idx + FW'(1);
                    n_state = S_ERD;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ostat = STAT_END;
                    n_oidx  = '0;
                    n_osize = '0;
                    n_ocen  = '0;
                    n_ocnt  = '0;
                    n_olast = 1'b1;
                    n_fill  = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_ostat <= n_ostat;
        r_oidx  <= n_oidx;
        r_osize <= n_osize;
        r_ocen  <= n_ocen;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
        if (accept) begin
            r_size <= {i_size_z, i_size_y, i_size_x};
            r_cen  <= {i_centre_z, i_centre_y, i_centre_x};
        end
        if (mean_done) begin
            case (r_k)
                3'd0:    r_msize[0] <= mean_q;
                3'd1:    r_msize[1] <= mean_q;
                3'd2:    r_msize[2] <= mean_q;
                3'd3:    r_mcen[0]  <= mean_q;
                3'd4:    r_mcen[1]  <= mean_q;
                default: r_mcen[2]  <= mean_q;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ostat;
    assign o_entry_index   = r_oidx;
    assign o_out_size_x    = r_osize[0];
    assign o_out_size_y    = r_osize[1];
    assign o_out_size_z    = r_osize[2];
    assign o_out_centre_x  = r_ocen[0];
    assign o_out_centre_y  = r_ocen[1];
    assign o_out_centre_z  = r_ocen[2];
    assign o_capture_count = r_ocnt;
    assign o_last          = r_olast;

    `BMMT_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(TABLE_DEPTH))
    `BMMT_ASSERT_NOW(a_write_state, i_clk, i_rst_n, mem_we, (r_state == S_MWR) || (r_state == S_ADD))
    `BMMT_ASSERT_NOW(a_mean_state, i_clk, i_rst_n, mean_done, r_state == S_MWAIT)
    `BMMT_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, (r_state == S_END) && out_free, r_fill == '0)

endmodule
